// ----- hdl/dat_pkg.sv -----
// ----------------------------------------------------------------------------
// dat_pkg
// Shared types and constants of the delayed action timer table: request
// codes, result kinds, status codes, field widths and the head event struct.
// ----------------------------------------------------------------------------
`default_nettype none

package dat_pkg;

    // Field widths fixed by the stream format.
    localparam int ACTION_W   = 3;
    localparam int FUNC_ID_W  = 8;
    localparam int DATA_W     = 16;
    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int SLOT_IDX_W = 6;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 32;

    // Widest action id supported, used for zero extension.
    localparam int ID_EXT_W = 16;

    // Request codes.
    localparam logic [ACTION_W-1:0] OP_START_REP  = 3'd0;
    localparam logic [ACTION_W-1:0] OP_START_FUSE = 3'd1;
    localparam logic [ACTION_W-1:0] OP_LENGTHEN   = 3'd2;
    localparam logic [ACTION_W-1:0] OP_EXTINGUISH = 3'd3;
    localparam logic [ACTION_W-1:0] OP_TICK_REP   = 3'd4;
    localparam logic [ACTION_W-1:0] OP_TICK_FUSE  = 3'd5;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_ACK       = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REP_RUN   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FUSE_FIRE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TICK_DONE = 2'd3;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ID_ZERO   = 2'd3;

    // Countdown value that marks a repeating action.
    localparam logic [DATA_W-1:0] CNT_REPEATING = 16'hFFFF;

    // What the head logic decides for the slot passing by.
    typedef struct packed {
        logic              emit;
        logic [KIND_W-1:0] kind;
        logic              hit;
    } head_evt_t;

endpackage

`default_nettype wire

// ----- hdl/delayed_action_timer_table.sv -----
// ----------------------------------------------------------------------------
// delayed_action_timer_table
// Table of timer slots for repeating actions and one-shot fuses, in a ring of
// cells rotating one slot per cycle past a shared update head unless stalled.
// ----------------------------------------------------------------------------
// Each request takes one pass of the ring. After the request is taken, the
// table rotates one slot per cycle, with the head logic applying the request
// to each slot in slot order; the ring holds while a result waits on a
// stalled output. After the last slot, the S_DONE state loads the final
// result, which is marked by tlast, once the output register is free.
// Tick requests emit a result for every slot that runs or fires, in slot
// order, before the final one. The next request is taken in the cycle after
// the final result is loaded into the output register.
`default_nettype none

module delayed_action_timer_table
    import dat_pkg::*;
#(
    parameter int SLOTS   = 20,
    parameter int ID_BITS = 8
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // Request stream.
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // s_tdata, lowest bit up: action[2:0], func_id[10:3], arg[26:11],
    // delay[42:27], zero fill[47:43].
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    // Result stream.
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // m_tdata, lowest bit up: status[1:0], run_id[9:2], run_arg[25:10],
    // slot_index[31:26].
    output logic      [OUT_TDATA_W-1:0] m_tdata,
    // m_tuser: kind[1:0].
    output logic      [KIND_W-1:0]      m_tuser,
    output logic                        m_tlast
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } state_t;

    // Control and request registers.
    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [ACTION_W-1:0] op_reg, op_next;
    logic [ID_BITS-1:0] id_reg, id_next;
    logic [DATA_W-1:0]  argin_reg, argin_next;
    logic [DATA_W-1:0]  delay_reg, delay_next;
    logic               found_reg, found_next;
    logic [IDX_W-1:0]   hit_idx_reg, hit_idx_next;
    logic [DATA_W-1:0]  hit_arg_reg, hit_arg_next;

    // Output register.
    logic                   m_valid_reg, m_valid_next;
    logic [KIND_W-1:0]      kind_reg, kind_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic [FUNC_ID_W-1:0]   run_id_reg, run_id_next;
    logic [DATA_W-1:0]      run_arg_reg, run_arg_next;
    logic [SLOT_IDX_W-1:0]  slot_reg, slot_next;
    logic                   last_reg, last_next;

    // Ring wiring.
    logic [ID_BITS-1:0] ring_act [SLOTS];
    logic [DATA_W-1:0]  ring_arg [SLOTS];
    logic [DATA_W-1:0]  ring_cnt [SLOTS];
    logic [ID_BITS-1:0] head_act;
    logic [DATA_W-1:0]  head_arg;
    logic [DATA_W-1:0]  head_cnt;
    head_evt_t          evt;

    logic                 out_free;
    logic                 step;
    logic                 last_slot;
    logic [ID_EXT_W-1:0]  fid_ext;
    logic [ID_BITS-1:0]   id_in;
    logic [ID_BITS+FUNC_ID_W-1:0] act_ext;
    logic [ID_BITS+FUNC_ID_W-1:0] req_id_ext;
    logic [FUNC_ID_W-1:0] act_id8;
    logic [FUNC_ID_W-1:0] req_id8;

    // Id masking to the table's id width, and back to the 8-bit result field.
    assign fid_ext    = {{(ID_EXT_W-FUNC_ID_W){1'b0}}, s_tdata[10:3]};
    assign id_in      = fid_ext[ID_BITS-1:0];
    assign act_ext    = {{FUNC_ID_W{1'b0}}, ring_act[0]};
    assign req_id_ext = {{FUNC_ID_W{1'b0}}, id_reg};
    assign act_id8    = act_ext[FUNC_ID_W-1:0];
    assign req_id8    = req_id_ext[FUNC_ID_W-1:0];

    assign out_free  = !m_valid_reg || m_tready;
    assign step      = (state_reg == S_WALK) && (!evt.emit || out_free);
    assign last_slot = (idx_reg == IDX_W'(SLOTS - 1));

    // Head update logic.
    dat_head #(
        .ID_BITS (ID_BITS)
    ) u_head (
        .op      (op_reg),
        .id      (id_reg),
        .arg_in  (argin_reg),
        .delay   (delay_reg),
        .found   (found_reg),
        .act     (ring_act[0]),
        .arg     (ring_arg[0]),
        .cnt     (ring_cnt[0]),
        .new_act (head_act),
        .new_arg (head_arg),
        .new_cnt (head_cnt),
        .evt     (evt)
    );

    // Ring of slot cells: each takes its upper neighbor, the tail takes the head.
    for (genvar g = 0; g < SLOTS; g++)
    begin : g_cell
        if (g == SLOTS - 1)
        begin : g_tail
            dat_cell #(
                .ID_BITS (ID_BITS)
            ) u_cell (
                .clk    (clk),
                .rst_n  (rst_n),
                .shift  (step),
                .in_act (head_act),
                .in_arg (head_arg),
                .in_cnt (head_cnt),
                .act    (ring_act[g]),
                .arg    (ring_arg[g]),
                .cnt    (ring_cnt[g])
            );
        end
        else
        begin : g_body
            dat_cell #(
                .ID_BITS (ID_BITS)
            ) u_cell (
                .clk    (clk),
                .rst_n  (rst_n),
                .shift  (step),
                .in_act (ring_act[g+1]),
                .in_arg (ring_arg[g+1]),
                .in_cnt (ring_cnt[g+1]),
                .act    (ring_act[g]),
                .arg    (ring_arg[g]),
                .cnt    (ring_cnt[g])
            );
        end
    end

    // Sequencer and output register next state.
    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        op_next      = op_reg;
        id_next      = id_reg;
        argin_next   = argin_reg;
        delay_next   = delay_reg;
        found_next   = found_reg;
        hit_idx_next = hit_idx_reg;
        hit_arg_next = hit_arg_reg;
        m_valid_next = m_valid_reg && !m_tready;
        kind_next    = kind_reg;
        status_next  = status_reg;
        run_id_next  = run_id_reg;
        run_arg_next = run_arg_reg;
        slot_next    = slot_reg;
        last_next    = last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_WALK;
                    idx_next   = '0;
                    op_next    = s_tdata[2:0];
                    id_next    = id_in;
                    argin_next = s_tdata[26:11];
                    delay_next = s_tdata[42:27];
                    found_next = 1'b0;
                end
            end
            S_WALK:
            begin
                if (step)
                begin
                    if (evt.hit)
                    begin
                        found_next   = 1'b1;
                        hit_idx_next = idx_reg;
                        hit_arg_next = head_arg;
                    end
                    if (evt.emit)
                    begin
                        m_valid_next = 1'b1;
                        kind_next    = evt.kind;
                        status_next  = ST_OK;
                        run_id_next  = act_id8;
                        run_arg_next = ring_arg[0];
                        slot_next    = SLOT_IDX_W'(idx_reg);
                        last_next    = 1'b0;
                    end
                    if (last_slot)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next   = S_IDLE;
                    m_valid_next = 1'b1;
                    kind_next    = KIND_ACK;
                    status_next  = ST_OK;
                    run_id_next  = '0;
                    run_arg_next = '0;
                    slot_next    = '0;
                    last_next    = 1'b1;
                    case (op_reg) inside
                        OP_START_REP, OP_START_FUSE, OP_LENGTHEN, OP_EXTINGUISH:
                        begin
                            if (id_reg == '0)
                            begin
                                status_next = ST_ID_ZERO;
                            end
                            else if (found_reg)
                            begin
                                run_id_next  = req_id8;
                                run_arg_next = hit_arg_reg;
                                slot_next    = SLOT_IDX_W'(hit_idx_reg);
                            end
                            else
                            begin
                                run_id_next = req_id8;
                                status_next = (op_reg == OP_START_REP ||
                                               op_reg == OP_START_FUSE) ?
                                              ST_FULL : ST_NOT_FOUND;
                            end
                        end
                        OP_TICK_REP, OP_TICK_FUSE:
                        begin
                            kind_next = KIND_TICK_DONE;
                        end
                        default:
                        begin
                            kind_next = KIND_ACK;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            idx_reg     <= '0;
            op_reg      <= '0;
            id_reg      <= '0;
            argin_reg   <= '0;
            delay_reg   <= '0;
            found_reg   <= 1'b0;
            hit_idx_reg <= '0;
            hit_arg_reg <= '0;
            m_valid_reg <= 1'b0;
            kind_reg    <= '0;
            status_reg  <= '0;
            run_id_reg  <= '0;
            run_arg_reg <= '0;
            slot_reg    <= '0;
            last_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            op_reg      <= op_next;
            id_reg      <= id_next;
            argin_reg   <= argin_next;
            delay_reg   <= delay_next;
            found_reg   <= found_next;
            hit_idx_reg <= hit_idx_next;
            hit_arg_reg <= hit_arg_next;
            m_valid_reg <= m_valid_next;
            kind_reg    <= kind_next;
            status_reg  <= status_next;
            run_id_reg  <= run_id_next;
            run_arg_reg <= run_arg_next;
            slot_reg    <= slot_next;
            last_reg    <= last_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {slot_reg, run_arg_reg, run_id_reg, status_reg};
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

`ifndef NO_ASSERTIONS
    // A taken request starts the ring walk at the first slot.
    a_walk_start: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == S_WALK && idx_reg == '0))
        else $error("walk did not start at slot zero");

    // The walk ends after the last slot has passed the head.
    a_walk_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK && step && last_slot) |=> (state_reg == S_DONE))
        else $error("walk did not end after the last slot");

    // Closing a request always loads a final result.
    a_final_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_free) |=> (m_tvalid && m_tlast && s_tready))
        else $error("final result missing");

    // The ring never rotates while a pending run result cannot be stored.
    a_no_lost_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (step && evt.emit) |-> out_free)
        else $error("ring stepped over a result");
`endif

endmodule

`default_nettype wire

// ----- hdl/dat_cell.sv -----
// ----------------------------------------------------------------------------
// dat_cell
// One slot of the timer ring. On each step it takes the slot held by its
// neighbor, so the whole table rotates one place toward the head.
// ----------------------------------------------------------------------------
`default_nettype none

module dat_cell
    import dat_pkg::*;
#(
    parameter int ID_BITS = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               shift,
    input  wire logic [ID_BITS-1:0] in_act,
    input  wire logic [DATA_W-1:0]  in_arg,
    input  wire logic [DATA_W-1:0]  in_cnt,
    output logic      [ID_BITS-1:0] act,
    output logic      [DATA_W-1:0]  arg,
    output logic      [DATA_W-1:0]  cnt
);

    logic [ID_BITS-1:0] act_reg;
    logic [DATA_W-1:0]  arg_reg;
    logic [DATA_W-1:0]  cnt_reg;

    // The action id must reset so that every slot starts empty.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= '0;
        end
        else if (shift)
        begin
            act_reg <= in_act;
        end
    end

    // Argument and countdown are only read in occupied slots.
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            arg_reg <= in_arg;
            cnt_reg <= in_cnt;
        end
    end

    assign act = act_reg;
    assign arg = arg_reg;
    assign cnt = cnt_reg;

endmodule

`default_nettype wire

// ----- hdl/dat_head.sv -----
// ----------------------------------------------------------------------------
// dat_head
// Update logic at the head of the ring. It applies the current request to
// the slot leaving the head cell and hands the new slot to the tail cell.
// ----------------------------------------------------------------------------
`default_nettype none

module dat_head
    import dat_pkg::*;
#(
    parameter int ID_BITS = 8
) (
    input  wire logic [ACTION_W-1:0] op,
    input  wire logic [ID_BITS-1:0]  id,
    input  wire logic [DATA_W-1:0]   arg_in,
    input  wire logic [DATA_W-1:0]   delay,
    input  wire logic                found,
    input  wire logic [ID_BITS-1:0]  act,
    input  wire logic [DATA_W-1:0]   arg,
    input  wire logic [DATA_W-1:0]   cnt,
    output logic      [ID_BITS-1:0]  new_act,
    output logic      [DATA_W-1:0]   new_arg,
    output logic      [DATA_W-1:0]   new_cnt,
    output head_evt_t                evt
);

    logic              id_ok;
    logic              occupied;
    logic [DATA_W:0]   sum;
    logic [DATA_W-1:0] sat;

    assign id_ok    = (id != '0);
    assign occupied = (act != '0);

    // Saturating add of the lengthen amount to the countdown.
    always_comb
    begin
        sum = {cnt[DATA_W-1], cnt} + {delay[DATA_W-1], delay};
        if (sum[DATA_W] != sum[DATA_W-1])
        begin
            sat = sum[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end
        else
        begin
            sat = sum[DATA_W-1:0];
        end
    end

    // Decode the request against the slot at the head.
    always_comb
    begin
        new_act  = act;
        new_arg  = arg;
        new_cnt  = cnt;
        evt.emit = 1'b0;
        evt.kind = KIND_ACK;
        evt.hit  = 1'b0;
        unique case (op) inside
            OP_START_REP, OP_START_FUSE:
            begin
                // The first free slot takes the new entry.
                if (id_ok && !found && !occupied)
                begin
                    evt.hit = 1'b1;
                    new_act = id;
                    new_arg = arg_in;
                    new_cnt = (op == OP_START_REP) ? CNT_REPEATING : delay;
                end
            end
            OP_LENGTHEN, OP_EXTINGUISH:
            begin
                // The first slot holding the id is changed.
                if (id_ok && !found && (act == id))
                begin
                    evt.hit = 1'b1;
                    if (op == OP_LENGTHEN)
                    begin
                        new_cnt = sat;
                    end
                    else
                    begin
                        new_act = '0;
                    end
                end
            end
            OP_TICK_REP:
            begin
                if (occupied && (cnt == CNT_REPEATING))
                begin
                    evt.emit = 1'b1;
                    evt.kind = KIND_REP_RUN;
                end
            end
            OP_TICK_FUSE:
            begin
                // Positive countdowns step down; a fuse reaching zero fires.
                if (occupied && !cnt[DATA_W-1] && (cnt != '0))
                begin
                    new_cnt = cnt - DATA_W'(1);
                    if (cnt == DATA_W'(1))
                    begin
                        evt.emit = 1'b1;
                        evt.kind = KIND_FUSE_FIRE;
                        new_act  = '0;
                    end
                end
            end
            default:
            begin
                new_act = act;
            end
        endcase
    end

endmodule

`default_nettype wire
